// ===== rtl/psh_pkg.sv =====
// shared types, constants and register map for the phase space histogram
package psh_pkg;

    localparam int VEL_BINS = 64;
    localparam int Y_BINS   = 64;
    localparam int VW       = $clog2(VEL_BINS);
    localparam int YW       = $clog2(Y_BINS);
    localparam int DEPTH    = VEL_BINS * Y_BINS;
    localparam int AW       = $clog2(DEPTH);
    localparam int ACC_W    = 48;
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    localparam logic [2:0] REG_VEL_MIN   = 3'd0;
    localparam logic [2:0] REG_Y_MIN     = 3'd1;
    localparam logic [2:0] REG_INV_VEL   = 3'd2;
    localparam logic [2:0] REG_INV_Y     = 3'd3;
    localparam logic [2:0] REG_MASS      = 3'd4;
    localparam logic [2:0] REG_WEIGHT    = 3'd5;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_SCALE,
        ST_BIN,
        ST_RD,
        ST_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic sq_step;
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic scale;
        logic bin;
        logic mem_rd;
        logic mem_wr;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic clr_last;
        logic sq_last;
        logic sqrt_last;
        logic div_last;
    } sts_t;

    typedef struct packed {
        logic signed [15:0] vel_min;
        logic signed [15:0] y_min;
        logic [31:0] inv_vel;
        logic [31:0] inv_y;
        logic [31:0] mass;
        logic [31:0] weight;
    } cfg_t;

endpackage

// ===== rtl/psh_ctrl.sv =====
// sequencer for the phase space histogram
module psh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  psh_pkg::sts_t sts,
    output psh_pkg::cmd_t cmd
);
    import psh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:   if (start) state_next = sts.is_read ? ST_RD : ST_SQUARE;
            ST_SQUARE: if (sts.sq_last) state_next = ST_SQRT;
            ST_SQRT:   if (sts.sqrt_last) state_next = ST_DIV;
            ST_DIV:    if (sts.div_last) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_BIN;
            ST_BIN:    state_next = ST_RD;
            ST_RD:     state_next = ST_WR;
            ST_WR:     state_next = ST_DONE;
            ST_DONE:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:  cmd.clr_step = 1'b1;
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                cmd.sqrt_init = 1'b0;
            end
            ST_SQUARE:
            begin
                cmd.sq_step   = 1'b1;
                cmd.sqrt_init = sts.sq_last;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cmd.div_init  = sts.sqrt_last;
            end
            ST_DIV:    cmd.div_step = 1'b1;
            ST_SCALE:  cmd.scale = 1'b1;
            ST_BIN:    cmd.bin = 1'b1;
            ST_RD:     cmd.mem_rd = 1'b1;
            ST_WR:     cmd.mem_wr = 1'b1;
            ST_DONE:   cmd.done = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== rtl/psh_datapath.sv =====
// arithmetic, histogram memory and result registers
module psh_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  psh_pkg::cmd_t      cmd,
    output psh_pkg::sts_t      sts,
    input  psh_pkg::cfg_t      cfg,
    input  logic               operation,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] mom_x,
    input  logic signed [31:0] mom_y,
    input  logic signed [31:0] mom_z,
    input  logic [5:0]         read_vel_index,
    input  logic [5:0]         read_y_index,
    output logic               done,
    output logic               in_range,
    output logic signed [15:0] vel_bin,
    output logic signed [15:0] y_bin,
    output logic [47:0]        bin_value
);
    import psh_pkg::*;

    logic [ACC_W-1:0] mem [DEPTH];

    logic              op_reg;
    logic signed [31:0] y_reg;
    logic              px_neg_reg;
    logic [31:0]       ax_reg, ay_reg, az_reg;
    logic [5:0]        rv_reg, ry_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [2:0]        sq_cnt_reg;
    logic [65:0]       sum_reg;
    logic [65:0]       rem_reg;
    logic [33:0]       root_reg;
    logic [5:0]        it_reg;
    logic [61:0]       num_reg;
    logic [62:0]       drem_reg;
    logic [30:0]       quo_reg;
    logic [63:0]       vprod_reg, yprod_reg;
    logic signed [17:0] nvr_reg;
    logic signed [33:0] nyr_reg;
    logic              hit_reg;
    logic [AW-1:0]     addr_reg;
    logic [ACC_W-1:0]  rd_reg;
    logic              done_reg, in_range_reg;
    logic signed [15:0] vel_bin_reg, y_bin_reg;
    logic [47:0]       bin_value_reg;

    logic [31:0] sq_op;
    logic [63:0] sq_prod;
    logic [33:0] e_val;
    logic [62:0] dtrial;
    logic [30:0] vmag;
    logic signed [17:0] nv, rv;
    logic signed [33:0] ny, ry;
    logic [48:0] acc_sum;
    logic        hit_next;
    logic [AW-1:0] addr_next;

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        mag = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        if (v > 34'sd32767)
        begin
            sat16 = 16'sh7fff;
        end
        else if (v < -34'sd32768)
        begin
            sat16 = -16'sh8000;
        end
        else
        begin
            sat16 = v[15:0];
        end
    endfunction

    always_comb
    begin
        case (sq_cnt_reg)
            3'd0:    sq_op = ax_reg;
            3'd1:    sq_op = ay_reg;
            3'd2:    sq_op = az_reg;
            default: sq_op = cfg.mass;
        endcase
    end
    assign sq_prod = sq_op * sq_op;

    // restoring square root, one result bit per cycle
    logic [67:0] rem_sh;
    assign rem_sh = {rem_reg, sum_reg[65:64]};
    logic [35:0] tv;
    assign tv = {root_reg, 2'b01};
    assign e_val = root_reg;

    assign vmag = (quo_reg > 31'h4000_0000) ? 31'h4000_0000 : quo_reg;
    assign dtrial = {drem_reg[61:0], num_reg[61]} - {29'b0, e_val};

    assign nv = 18'(vprod_reg[63:46]);
    assign ny = 34'(yprod_reg[63:32]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            done_reg <= cmd.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            y_reg      <= pos_y;
            px_neg_reg <= mom_x[31];
            ax_reg     <= mag(mom_x);
            ay_reg     <= mag(mom_y);
            az_reg     <= mag(mom_z);
            rv_reg     <= read_vel_index;
            ry_reg     <= read_y_index;
            sq_cnt_reg <= '0;
            sum_reg    <= '0;
        end
        if (cmd.sq_step)
        begin
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
            sum_reg    <= sum_reg + 66'(sq_prod[63:2]);
        end
        if (cmd.sqrt_init)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_init || cmd.div_init)
        begin
            it_reg <= '0;
        end
        else if (cmd.sqrt_step || cmd.div_step)
        begin
            it_reg <= it_reg + 1'b1;
        end
        if (cmd.sqrt_step)
        begin
            // bring down two bits of the radicand
            if (rem_sh >= 68'(tv))
            begin
                rem_reg  <= 66'(rem_sh - 68'(tv));
                root_reg <= {root_reg[32:0], 1'b1};
            end
            else
            begin
                rem_reg  <= 66'(rem_sh);
                root_reg <= {root_reg[32:0], 1'b0};
            end
            sum_reg <= {sum_reg[63:0], 2'b00};
        end
        if (cmd.div_init)
        begin
            num_reg  <= {1'b0, ax_reg, 29'b0};
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            // long division, quotient saturates through its top bit
            if ({drem_reg[61:0], num_reg[61]} >= {29'b0, e_val})
            begin
                drem_reg <= dtrial;
                quo_reg  <= {quo_reg[29:0], 1'b1} | {quo_reg[30], 30'b0};
            end
            else
            begin
                drem_reg <= {drem_reg[61:0], num_reg[61]};
                quo_reg  <= {quo_reg[29:0], 1'b0} | {quo_reg[30], 30'b0};
            end
            num_reg <= {num_reg[60:0], 1'b0};
        end
        if (cmd.scale)
        begin
            vprod_reg <= (e_val == '0 ? 64'd0 : 64'(vmag) * 64'(cfg.inv_vel))
                         + (64'd1 << 45);
            yprod_reg <= 64'(mag(y_reg)) * 64'(cfg.inv_y) + (64'd1 << 31);
        end
        if (cmd.bin)
        begin
            nvr_reg <= px_neg_reg ? -nv : nv;
            nyr_reg <= y_reg[31] ? -ny : ny;
        end
        if (cmd.mem_rd)
        begin
            hit_reg  <= hit_next;
            addr_reg <= addr_next;
        end
        if (cmd.mem_wr)
        begin
            in_range_reg  <= hit_reg;
            bin_value_reg <= (op_reg == OP_READ && hit_reg) ? rd_reg : '0;
            vel_bin_reg   <= op_reg == OP_READ ? 16'(rv_reg) : sat16(34'(rv));
            y_bin_reg     <= op_reg == OP_READ ? 16'(ry_reg) : sat16(ry);
        end
    end

    assign rv = nvr_reg - 18'(cfg.vel_min);
    assign ry = nyr_reg - 34'(cfg.y_min);
    assign acc_sum = {1'b0, rd_reg} + 49'(cfg.weight);

    always_comb
    begin
        if (op_reg == OP_READ)
        begin
            hit_next  = 1'b1;
            addr_next = AW'({rv_reg, ry_reg});
        end
        else
        begin
            hit_next  = (rv >= 0) && (rv < 18'(VEL_BINS))
                        && (ry >= 0) && (ry < 34'(Y_BINS));
            addr_next = AW'({rv[VW-1:0], ry[YW-1:0]});
        end
    end

    // histogram memory: one read, one write port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            rd_reg <= mem[addr_next];
        end
        if (cmd.clr_step)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.mem_wr && hit_reg)
        begin
            if (op_reg == OP_READ)
            begin
                mem[addr_reg] <= '0;
            end
            else
            begin
                mem[addr_reg] <= acc_sum[48] ? ACC_MAX : acc_sum[47:0];
            end
        end
    end

    assign sts.is_read   = operation;
    assign sts.clr_last  = clr_cnt_reg == AW'(DEPTH - 1);
    assign sts.sq_last   = sq_cnt_reg == 3'd3;
    assign sts.sqrt_last = it_reg == 6'd32;
    assign sts.div_last  = it_reg == 6'd61;

    assign done      = done_reg;
    assign in_range  = in_range_reg;
    assign vel_bin   = vel_bin_reg;
    assign y_bin     = y_bin_reg;
    assign bin_value = bin_value_reg;

endmodule

// ===== rtl/psh_regs.sv =====
// configuration register file on the apb port
module psh_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output psh_pkg::cfg_t cfg
);
    import psh_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] idx;

    assign idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vel_min <= -16'sd32;
            cfg_reg.y_min   <= 16'sd0;
            cfg_reg.inv_vel <= 32'd2097152;
            cfg_reg.inv_y   <= 32'd65536;
            cfg_reg.mass    <= 32'd65536;
            cfg_reg.weight  <= 32'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_VEL_MIN: cfg_reg.vel_min <= pwdata[15:0];
                REG_Y_MIN:   cfg_reg.y_min   <= pwdata[15:0];
                REG_INV_VEL: cfg_reg.inv_vel <= pwdata;
                REG_INV_Y:   cfg_reg.inv_y   <= pwdata;
                REG_MASS:    cfg_reg.mass    <= pwdata;
                REG_WEIGHT:  cfg_reg.weight  <= pwdata;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_VEL_MIN: prdata = 32'(signed'(cfg_reg.vel_min));
            REG_Y_MIN:   prdata = 32'(signed'(cfg_reg.y_min));
            REG_INV_VEL: prdata = cfg_reg.inv_vel;
            REG_INV_Y:   prdata = cfg_reg.inv_y;
            REG_MASS:    prdata = cfg_reg.mass;
            REG_WEIGHT:  prdata = cfg_reg.weight;
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/phase_space_histogram_unit.sv =====
// phase space histogram top level
// accumulate: from start to done the sequencer runs 4 squares, 33 root steps,
// 62 division steps, scale, bin, memory read and write; readout: memory read
// and write only; one item at a time; busy stays high until the result strobe
// after reset a clearing pass zeroes all 4096 entries of the store, busy high
// done marks each result for one cycle; the receiver cannot stall
module phase_space_histogram_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] mom_x,
    input  logic signed [31:0] mom_y,
    input  logic signed [31:0] mom_z,
    input  logic [5:0]         read_vel_index,
    input  logic [5:0]         read_y_index,
    output logic               done,
    output logic               in_range,
    output logic signed [15:0] vel_bin,
    output logic signed [15:0] y_bin,
    output logic [47:0]        bin_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import psh_pkg::*;

    cmd_t cmd;
    sts_t sts;
    cfg_t cfg;

    assign pready = 1'b1;

    psh_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
    );

    psh_ctrl u_ctrl (
        .clk, .rst_n, .start, .busy, .sts, .cmd
    );

    psh_datapath u_dp (
        .clk, .rst_n, .cmd, .sts, .cfg, .operation, .pos_y, .mom_x, .mom_y,
        .mom_z, .read_vel_index, .read_y_index, .done, .in_range, .vel_bin,
        .y_bin, .bin_value
    );

endmodule

// ===== rtl/psh_checker.sv =====
// port level checks for the phase space histogram
module psh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        in_range,
    input logic [47:0] bin_value
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy low after transfer");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without work");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_range |-> bin_value == 48'd0)
        else $error("value on dropped item");
endmodule

bind phase_space_histogram_unit psh_checker u_chk (
    .clk, .rst_n, .start, .busy, .done, .in_range, .bin_value
);
